// ===== hdl/iet_pkg.sv =====
package iet_pkg;
  localparam int MaxBins = 32;
  localparam int QeWidth = 16;
  localparam int IdxW = $clog2(MaxBins);
  localparam int EW = 24;
  localparam int WlW = 16;
  localparam int ConvNum = 19890;
  localparam int DivW = 35;
  localparam logic [EW-1:0] EnergyMax = {EW{1'b1}};

  typedef enum logic [1:0] {
    CMD_LOAD_E = 2'd0,
    CMD_LOAD_WL = 2'd1,
    CMD_QUERY_E = 2'd2,
    CMD_QUERY_WL = 2'd3
  } cmd_t;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic scan_start;
    logic scan_step;
    logic interp_start;
    logic write_tbl;
    logic out_load;
  } iet_ctl_t;

  typedef struct packed {
    logic div_done;
    logic scan_last;
    logic interp_done;
  } iet_sts_t;
endpackage

// ===== hdl/interpolated_efficiency_table.sv =====
// query: out_valid after the bin scan and the interpolation divide, and after the wavelength divide for a wavelength
// load: by energy the table is written directly, by wavelength after the divider (cut short for a zero wavelength)
// one item at a time; the serial dividers (35 and 40 steps) and the bin scan set the rate
// a finished result waits in the output register while the next item is taken
// synchronous active-low reset sets num_bins to 20; table contents are not reset
module interpolated_efficiency_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [4:0]  in_bin_index,
  input  logic [23:0] in_energy_in,
  input  logic [15:0] in_wavelength_in,
  input  logic [15:0] in_qe_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_qe_out,
  output logic [23:0] out_energy_out,
  output logic        out_in_range,
  output logic        out_bad_wavelength,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_num_bins
);
  import iet_pkg::*;
  logic [5:0] nb_r;
  iet_ctl_t ctl;
  iet_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) nb_r <= 6'd20;
    else if (cfg_we) nb_r <= cfg_num_bins;
  end

  iet_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_ready, .in_cmd, .out_valid, .out_ready,
    .num_bins(nb_r), .ctl, .sts);
  iet_datapath u_dp (.clk, .rst_n, .ctl, .sts, .num_bins(nb_r), .in_cmd, .in_bin_index,
    .in_energy_in, .in_wavelength_in, .in_qe_in, .out_qe_out, .out_energy_out,
    .out_in_range, .out_bad_wavelength);
endmodule

// ===== hdl/iet_datapath.sv =====
module iet_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iet_pkg::iet_ctl_t    ctl,
  output iet_pkg::iet_sts_t    sts,
  input  logic [5:0]           num_bins,
  input  logic [1:0]           in_cmd,
  input  logic [4:0]           in_bin_index,
  input  logic [23:0]          in_energy_in,
  input  logic [15:0]          in_wavelength_in,
  input  logic [15:0]          in_qe_in,
  output logic [15:0]          out_qe_out,
  output logic [23:0]          out_energy_out,
  output logic                 out_in_range,
  output logic                 out_bad_wavelength
);
  import iet_pkg::*;

  logic [EW-1:0]      etab [MaxBins];
  logic [QeWidth-1:0] qtab [MaxBins];

  logic [1:0]   cmd_r;
  logic [4:0]   idx_r;
  logic [EW-1:0] e_r;
  logic [WlW-1:0] wl_r;
  logic [QeWidth-1:0] qe_r;
  logic         bad_r;

  // restoring divider
  logic [DivW-1:0] quo_r;
  logic [WlW:0]    rem_r;
  logic [5:0]      dcnt_r;
  logic [DivW-1:0] dividend;
  logic [WlW:0]    rem_sh;
  assign dividend = DivW'(ConvNum) << 20;
  assign rem_sh = {rem_r[WlW-1:0], quo_r[DivW-1]};

  // scan
  logic [IdxW-1:0] si_r;
  logic [EW-1:0]   e1_r, e2_r;
  logic [QeWidth-1:0] q1_r, q2_r;
  logic         hit_r, eq_r;
  logic [IdxW:0] nlim;
  assign nlim = (num_bins > 6'(MaxBins)) ? (IdxW+1)'(MaxBins) : (IdxW+1)'(num_bins);

  // interpolation divider: num/(e2-e1)
  logic [EW+QeWidth-1:0] num_r;
  logic [EW:0]  irem_r;
  logic [EW-1:0] d_r;
  logic [5:0]   icnt_r;
  logic         neg_r;
  logic [QeWidth-1:0] res_r;
  logic [EW:0]  irem_sh;
  assign irem_sh = {irem_r[EW-1:0], num_r[EW+QeWidth-1]};

  logic [IdxW-1:0] rd_idx;
  assign rd_idx = si_r;
  logic [EW-1:0] ea, eb;
  logic [QeWidth-1:0] qa, qb;
  logic brk;
  assign ea = etab[rd_idx];
  assign eb = etab[rd_idx + 1'b1];
  assign qa = qtab[rd_idx];
  assign qb = qtab[rd_idx + 1'b1];
  assign brk = (e_r >= ea) && (e_r <= eb);

  logic [QeWidth-1:0] qd;
  logic [EW-1:0] xd;
  assign qd = neg_r ? (q1_r - q2_r) : (q2_r - q1_r);
  assign xd = e_r - e1_r;

  logic [EW+QeWidth-1:0] quot_fix;
  always_comb begin
    quot_fix = num_r;
    if (neg_r && irem_r != '0) quot_fix = num_r + 1'b1;
  end

  assign sts.div_done = (dcnt_r == 6'(DivW));
  assign sts.scan_last = ((IdxW+1)'(si_r) + 2 >= nlim);
  assign sts.interp_done = (icnt_r == 6'(EW+QeWidth + 1));

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r <= in_cmd; idx_r <= in_bin_index; e_r <= in_energy_in;
      wl_r <= in_wavelength_in; qe_r <= in_qe_in; bad_r <= 1'b0;
      quo_r <= dividend; rem_r <= '0; dcnt_r <= '0;
    end else if (ctl.div_start && (cmd_r == CMD_LOAD_WL || cmd_r == CMD_QUERY_WL)) begin
      if (wl_r == '0) begin
        bad_r <= 1'b1; e_r <= '0; dcnt_r <= 6'(DivW);
      end else if (!sts.div_done) begin
        if (rem_sh >= {1'b0, wl_r}) begin
          rem_r <= rem_sh - {1'b0, wl_r};
          quo_r <= {quo_r[DivW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[DivW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 1'b1;
        if (dcnt_r == 6'(DivW-1))
          e_r <= (quo_r[DivW-2:EW-1] != '0) ? EnergyMax : {quo_r[EW-2:0], rem_sh >= {1'b0, wl_r}};
      end
    end
    if (ctl.write_tbl) begin
      etab[idx_r] <= e_r;
      qtab[idx_r] <= qe_r;
    end
    if (ctl.scan_start) begin
      si_r <= '0; hit_r <= 1'b0;
    end else if (ctl.scan_step) begin
      if ((IdxW+1)'(si_r) + 1 < nlim && brk) begin
        hit_r <= 1'b1; e1_r <= ea; e2_r <= eb; q1_r <= qa; q2_r <= qb;
      end
      si_r <= si_r + 1'b1;
    end
    if (ctl.interp_start) begin
      eq_r <= (e1_r == e2_r);
      neg_r <= (q2_r < q1_r);
      d_r <= e2_r - e1_r;
      icnt_r <= '0;
      irem_r <= '0;
    end else if (!sts.interp_done) begin
      if (icnt_r == '0) begin
        num_r <= (EW+QeWidth)'(qd) * (EW+QeWidth)'(xd);
        icnt_r <= 6'd1;
      end else begin
        if (irem_sh >= {1'b0, d_r}) begin
          irem_r <= irem_sh - {1'b0, d_r};
          num_r <= {num_r[EW+QeWidth-2:0], 1'b1};
        end else begin
          irem_r <= irem_sh;
          num_r <= {num_r[EW+QeWidth-2:0], 1'b0};
        end
        icnt_r <= icnt_r + 1'b1;
      end
    end
    if (ctl.out_load) begin
      out_energy_out <= e_r;
      out_bad_wavelength <= bad_r;
      out_in_range <= hit_r;
      if (!hit_r) out_qe_out <= '0;
      else if (eq_r) out_qe_out <= q1_r;
      else if (neg_r) out_qe_out <= q1_r - quot_fix[QeWidth-1:0];
      else out_qe_out <= q1_r + quot_fix[QeWidth-1:0];
    end
    if (!rst_n) begin
      dcnt_r <= '0;
      icnt_r <= 6'(EW+QeWidth + 1);
    end
  end
endmodule

// ===== hdl/iet_ctrl.sv =====
module iet_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic [5:0]        num_bins,
  output iet_pkg::iet_ctl_t ctl,
  input  iet_pkg::iet_sts_t sts
);
  import iet_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_WRITE, S_SCAN, S_PREP, S_IDIV, S_OUT} state_t;
  state_t state_r;
  logic [1:0] cmd_r;
  logic ov_r;
  logic div_ok;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign div_ok = sts.div_done || (cmd_r != CMD_LOAD_WL && cmd_r != CMD_QUERY_WL);

  always_comb begin
    ctl = '0;
    ctl.load_in = in_valid && in_ready;
    ctl.div_start = (state_r == S_DIV);
    ctl.write_tbl = (state_r == S_WRITE);
    ctl.scan_start = (state_r == S_DIV) && div_ok;
    ctl.scan_step = (state_r == S_SCAN);
    ctl.interp_start = (state_r == S_PREP);
    ctl.out_load = (state_r == S_OUT) && (!ov_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; cmd_r <= '0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid) begin
          cmd_r <= in_cmd;
          state_r <= S_DIV;
        end
        S_DIV: if (div_ok) begin
          state_r <= (cmd_r == CMD_LOAD_E || cmd_r == CMD_LOAD_WL) ? S_WRITE : S_SCAN;
        end
        S_WRITE: state_r <= S_IDLE;
        S_SCAN: if (sts.scan_last || num_bins < 6'd2) state_r <= S_PREP;
        S_PREP: state_r <= S_IDIV;
        S_IDIV: if (sts.interp_done) state_r <= S_OUT;
        S_OUT: if (!ov_r || out_ready) begin
          ov_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_rdy: assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> state_r == S_IDLE)
    else $error("ready outside idle");
  a_out: assert property (@(posedge clk) disable iff (!rst_n) ctl.out_load |=> ov_r)
    else $error("result lost");
  a_wr: assert property (@(posedge clk) disable iff (!rst_n) ctl.write_tbl |=> state_r == S_IDLE)
    else $error("write not single");
endmodule
